// File: sv/three_level_feedback_queue_scheduler_macros.svh
// Assertion macros for the three-level feedback queue scheduler.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef THREE_LEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`define THREE_LEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLFQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define TLFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TLFQ_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TLFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: sv/tlfq_pkg.sv
// Shared constants, types and helpers for the three-level feedback queue scheduler.
// No dependencies.
package tlfq_pkg;

   localparam int MAX_PROCS_DEF   = 16;
   localparam int BURST_WIDTH_DEF = 16;
   localparam int NUM_LEVELS      = 3;
   localparam int ID_W            = 4;
   localparam int LEVEL_W         = 2;
   localparam int QUANTUM_W       = 8;
   localparam int BURST_IN_W      = 16;
   localparam int CSR_INDEX_W     = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUANTUM_L0 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUANTUM_L1 = 2'd1;

   localparam logic [QUANTUM_W-1:0] QUANTUM_L0_RESET = 8'd2;
   localparam logic [QUANTUM_W-1:0] QUANTUM_L1_RESET = 8'd4;

   localparam logic [LEVEL_W-1:0] LEVEL_0 = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_1 = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_2 = 2'd2;

   // queue operations for one tick
   typedef struct packed {
      logic                push_arrival;  // new process joins level 0
      logic                pop;           // head of pop_level leaves its level
      logic [LEVEL_W-1:0]  pop_level;
      logic                demote;        // popped process joins pop_level + 1
   } queue_ctl_type;

   typedef struct packed {
      logic                idle;
      logic [ID_W-1:0]     running_id;
      logic [LEVEL_W-1:0]  running_level;
      logic                finished;
      logic                demoted;
      logic                arrival_dropped;
   } result_type;

   // a zero quantum behaves as one tick
   function automatic logic [QUANTUM_W-1:0] load_quantum(input logic [QUANTUM_W-1:0] q);
      return (q == '0) ? QUANTUM_W'(1) : q;
   endfunction

endpackage

// File: sv/tlfq_queues.sv
// Three ready queues kept as linked lists over the process slots.
// Depends on tlfq_pkg.
module tlfq_queues #(
   parameter int MAX_PROCS = tlfq_pkg::MAX_PROCS_DEF,
   parameter int PROC_W    = $clog2(MAX_PROCS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tlfq_pkg::queue_ctl_type       ctl,
   input  logic [PROC_W-1:0]             arrival_idx,
   input  logic [PROC_W-1:0]             running_idx,
   output logic [tlfq_pkg::NUM_LEVELS-1:0] nonempty,
   output logic [PROC_W-1:0]             heads [tlfq_pkg::NUM_LEVELS]
);

   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   logic [PROC_W-1:0] head_ff  [tlfq_pkg::NUM_LEVELS];
   logic [PROC_W-1:0] head_in  [tlfq_pkg::NUM_LEVELS];
   logic [PROC_W-1:0] tail_ff  [tlfq_pkg::NUM_LEVELS];
   logic [PROC_W-1:0] tail_in  [tlfq_pkg::NUM_LEVELS];
   logic [CNT_W-1:0]  count_ff [tlfq_pkg::NUM_LEVELS];
   logic [CNT_W-1:0]  count_in [tlfq_pkg::NUM_LEVELS];
   logic [PROC_W-1:0] link_ff  [MAX_PROCS];

   logic [tlfq_pkg::NUM_LEVELS-1:0] push_en;
   logic [tlfq_pkg::NUM_LEVELS-1:0] pop_en;
   logic [PROC_W-1:0]               push_id [tlfq_pkg::NUM_LEVELS];

   always_comb begin
      for (int l = 0; l < tlfq_pkg::NUM_LEVELS; l++) begin
         pop_en[l] = ctl.pop && (ctl.pop_level == tlfq_pkg::LEVEL_W'(l));
         if (l == 0) begin
            push_en[l] = ctl.push_arrival;
            push_id[l] = arrival_idx;
         end else begin
            push_en[l] = ctl.demote && (ctl.pop_level == tlfq_pkg::LEVEL_W'(l - 1));
            push_id[l] = running_idx;
         end

         count_in[l] = count_ff[l] + CNT_W'(push_en[l]) - CNT_W'(pop_en[l]);
         head_in[l]  = head_ff[l];
         tail_in[l]  = tail_ff[l];
         if (push_en[l]) begin
            tail_in[l] = push_id[l];
            if (count_ff[l] == '0) begin
               head_in[l] = push_id[l];
            end
         end
         if (pop_en[l]) begin
            // single entry replaced by this tick's push: its link is not written yet
            if (count_ff[l] == CNT_W'(1) && push_en[l]) begin
               head_in[l] = push_id[l];
            end else begin
               head_in[l] = link_ff[head_ff[l]];
            end
         end
         nonempty[l] = (count_ff[l] != '0);
         heads[l]    = head_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < tlfq_pkg::NUM_LEVELS; l++) begin
            count_ff[l] <= '0;
         end
      end else begin
         for (int l = 0; l < tlfq_pkg::NUM_LEVELS; l++) begin
            count_ff[l] <= count_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < tlfq_pkg::NUM_LEVELS; l++) begin
         head_ff[l] <= head_in[l];
         tail_ff[l] <= tail_in[l];
         if (push_en[l] && count_ff[l] != '0) begin
            link_ff[tail_ff[l]] <= push_id[l];
         end
      end
   end

endmodule

// File: sv/tlfq_core.sv
// Per-tick scheduling step: admission, level pick, counter update, demotion.
// Depends on tlfq_pkg and tlfq_queues.
module tlfq_core #(
   parameter int MAX_PROCS   = tlfq_pkg::MAX_PROCS_DEF,
   parameter int BURST_WIDTH = tlfq_pkg::BURST_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   input  logic                               arrival_valid,
   input  logic [tlfq_pkg::ID_W-1:0]          arrival_id,
   input  logic [tlfq_pkg::BURST_IN_W-1:0]    arrival_burst,
   input  logic [tlfq_pkg::QUANTUM_W-1:0]     quantum_l0,
   input  logic [tlfq_pkg::QUANTUM_W-1:0]     quantum_l1,
   output tlfq_pkg::result_type               result
);

   localparam int PROC_W = $clog2(MAX_PROCS);
   localparam int EXT_W  = 32;

   logic [MAX_PROCS-1:0]             active_ff;
   logic [MAX_PROCS-1:0]             active_in;
   logic [BURST_WIDTH-1:0]           burst_ff   [MAX_PROCS];
   logic [tlfq_pkg::QUANTUM_W-1:0]   quantum_ff [MAX_PROCS];

   logic [EXT_W-1:0]                 aid_ext;
   logic [EXT_W-1:0]                 burst_ext;
   logic [EXT_W-1:0]                 rid_ext;
   logic [PROC_W-1:0]                aid_idx;
   logic [BURST_WIDTH-1:0]           burst_masked;
   logic                             admit_ok;
   logic                             accept;
   logic [tlfq_pkg::NUM_LEVELS-1:0]  nonempty;
   logic [PROC_W-1:0]                heads [tlfq_pkg::NUM_LEVELS];
   logic                             ne0;
   logic                             run;
   logic [tlfq_pkg::LEVEL_W-1:0]     lvl;
   logic [PROC_W-1:0]                rid;
   logic                             fresh;
   logic [BURST_WIDTH-1:0]           cur_burst;
   logic [BURST_WIDTH-1:0]           burst_left;
   logic [tlfq_pkg::QUANTUM_W-1:0]   cur_quantum;
   logic [tlfq_pkg::QUANTUM_W-1:0]   quantum_left;
   logic [tlfq_pkg::QUANTUM_W-1:0]   q0_load;
   logic [tlfq_pkg::QUANTUM_W-1:0]   q1_load;
   logic                             has_quantum;
   logic                             fin;
   logic                             dem;
   tlfq_pkg::queue_ctl_type          qctl;

   assign aid_ext      = EXT_W'(arrival_id);
   assign aid_idx      = aid_ext[PROC_W-1:0];
   assign burst_ext    = EXT_W'(arrival_burst);
   assign burst_masked = burst_ext[BURST_WIDTH-1:0];
   assign q0_load      = tlfq_pkg::load_quantum(quantum_l0);
   assign q1_load      = tlfq_pkg::load_quantum(quantum_l1);

   assign admit_ok = (aid_ext < EXT_W'(MAX_PROCS)) && (burst_masked != '0) &&
                     !active_ff[aid_idx];
   assign accept   = item_valid && arrival_valid && admit_ok;

   always_comb begin
      ne0 = nonempty[0] || accept;
      if (ne0) begin
         lvl = tlfq_pkg::LEVEL_0;
         rid = nonempty[0] ? heads[0] : aid_idx;
      end else if (nonempty[1]) begin
         lvl = tlfq_pkg::LEVEL_1;
         rid = heads[1];
      end else begin
         lvl = tlfq_pkg::LEVEL_2;
         rid = heads[2];
      end
      run         = item_valid && (ne0 || nonempty[1] || nonempty[2]);
      // the arrival that runs in its own tick is not in the tables yet
      fresh       = accept && (rid == aid_idx);
      cur_burst   = fresh ? burst_masked : burst_ff[rid];
      cur_quantum = fresh ? q0_load : quantum_ff[rid];
      burst_left  = cur_burst - BURST_WIDTH'(1);
      quantum_left = cur_quantum - tlfq_pkg::QUANTUM_W'(1);
      has_quantum = (lvl != tlfq_pkg::LEVEL_2);
      fin         = (burst_left == '0);
      dem         = !fin && has_quantum && (quantum_left == '0);
      rid_ext     = EXT_W'(rid);
   end

   always_comb begin
      qctl.push_arrival = accept;
      qctl.pop          = run && (fin || dem);
      qctl.pop_level    = lvl;
      qctl.demote       = run && dem;

      result.idle            = !run;
      result.running_id      = run ? rid_ext[tlfq_pkg::ID_W-1:0] : '0;
      result.running_level   = run ? lvl : tlfq_pkg::LEVEL_0;
      result.finished        = run && fin;
      result.demoted         = run && dem;
      result.arrival_dropped = arrival_valid && !admit_ok;
   end

   tlfq_queues #(
      .MAX_PROCS (MAX_PROCS),
      .PROC_W    (PROC_W)
   ) u_queues (
      .clock       (clock),
      .reset       (reset),
      .ctl         (qctl),
      .arrival_idx (aid_idx),
      .running_idx (rid),
      .nonempty    (nonempty),
      .heads       (heads)
   );

   // admission sets the flag, a finishing run clears it (same id: cleared)
   always_comb begin
      active_in = active_ff;
      if (accept) begin
         active_in[aid_idx] = 1'b1;
      end
      if (run && fin) begin
         active_in[rid] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   // an arrival that runs in its own tick takes only the running update
   always_ff @(posedge clock) begin
      if (accept && !fresh) begin
         burst_ff[aid_idx]   <= burst_masked;
         quantum_ff[aid_idx] <= q0_load;
      end
      if (run) begin
         burst_ff[rid] <= burst_left;
         if (dem && lvl == tlfq_pkg::LEVEL_0) begin
            quantum_ff[rid] <= q1_load;
         end else if (has_quantum) begin
            quantum_ff[rid] <= quantum_left;
         end
      end
   end

endmodule

// File: sv/three_level_feedback_queue_scheduler.sv
// Top level of the three-level feedback queue scheduler: ports, request and
// result registers, quantum registers. Depends on tlfq_pkg, tlfq_core, tlfq_queues.
//
//   channel   ports                                       transfer when
//   --------  ------------------------------------------  ------------------------
//   request   start, busy, req_arrival_*                  start && !busy
//   result    rsp_valid, rsp_*                            rsp_valid (one cycle)
//   config    csr_valid, csr_ready, csr_index, csr_wdata  csr_valid && csr_ready
//
// One tick per clock: a new request transfer is taken every cycle while busy is low.
// A request passes through the request register, then the scheduling step
// (queue links and per-process counters updated read-modify-write) into
// the result register.
// Reset is synchronous; busy is high for the cycle after reset is released.
// The result side cannot stall: each result is shown for exactly one cycle.
`include "three_level_feedback_queue_scheduler_macros.svh"

module three_level_feedback_queue_scheduler #(
   parameter int MAX_PROCS   = tlfq_pkg::MAX_PROCS_DEF,
   parameter int BURST_WIDTH = tlfq_pkg::BURST_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_arrival_valid,
   input  logic [tlfq_pkg::ID_W-1:0]           req_arrival_id,
   input  logic [tlfq_pkg::BURST_IN_W-1:0]     req_arrival_burst,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tlfq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tlfq_pkg::QUANTUM_W-1:0]      csr_wdata,
   // result channel
   output logic                                rsp_valid,
   output logic                                rsp_idle,
   output logic [tlfq_pkg::ID_W-1:0]           rsp_running_id,
   output logic [tlfq_pkg::LEVEL_W-1:0]        rsp_running_level,
   output logic                                rsp_finished,
   output logic                                rsp_demoted,
   output logic                                rsp_arrival_dropped
);

   logic                                 busy_ff;
   logic                                 item_valid_ff;
   logic                                 arrival_valid_ff;
   logic [tlfq_pkg::ID_W-1:0]            arrival_id_ff;
   logic [tlfq_pkg::BURST_IN_W-1:0]      arrival_burst_ff;
   logic [tlfq_pkg::QUANTUM_W-1:0]       quantum_l0_ff;
   logic [tlfq_pkg::QUANTUM_W-1:0]       quantum_l1_ff;
   logic                                 rsp_valid_ff;
   tlfq_pkg::result_type                 rsp_ff;
   tlfq_pkg::result_type                 step_result;
   logic                                 req_fire;
   logic                                 csr_fire;

   assign req_fire  = start && !busy_ff;
   assign csr_ready = 1'b1;   // quantum registers take a write any cycle
   assign csr_fire  = csr_valid && csr_ready;
   assign busy      = busy_ff;

   // control: valid pipeline and quantum registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         quantum_l0_ff <= tlfq_pkg::QUANTUM_L0_RESET;
         quantum_l1_ff <= tlfq_pkg::QUANTUM_L1_RESET;
      end else begin
         busy_ff       <= 1'b0;
         item_valid_ff <= req_fire;
         rsp_valid_ff  <= item_valid_ff;
         if (csr_fire && csr_index == tlfq_pkg::CSR_QUANTUM_L0) begin
            quantum_l0_ff <= csr_wdata;
         end
         if (csr_fire && csr_index == tlfq_pkg::CSR_QUANTUM_L1) begin
            quantum_l1_ff <= csr_wdata;
         end
      end
   end

   // payload: captured request and registered result
   always_ff @(posedge clock) begin
      if (req_fire) begin
         arrival_valid_ff <= req_arrival_valid;
         arrival_id_ff    <= req_arrival_id;
         arrival_burst_ff <= req_arrival_burst;
      end
      if (item_valid_ff) begin
         rsp_ff <= step_result;
      end
   end

   // one scheduling tick per registered request
   tlfq_core #(
      .MAX_PROCS   (MAX_PROCS),
      .BURST_WIDTH (BURST_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid_ff),
      .arrival_valid (arrival_valid_ff),
      .arrival_id    (arrival_id_ff),
      .arrival_burst (arrival_burst_ff),
      .quantum_l0    (quantum_l0_ff),
      .quantum_l1    (quantum_l1_ff),
      .result        (step_result)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_idle            = rsp_ff.idle;
   assign rsp_running_id      = rsp_ff.running_id;
   assign rsp_running_level   = rsp_ff.running_level;
   assign rsp_finished        = rsp_ff.finished;
   assign rsp_demoted         = rsp_ff.demoted;
   assign rsp_arrival_dropped = rsp_ff.arrival_dropped;

   // every request transfer yields its result through the request and result registers
   `TLFQ_ASSERT_NEXT(a_rsp_latency, clock, reset, $past(start && !busy && !reset), rsp_valid, "result missing two cycles after request transfer")
   // no result without an earlier request transfer through the request and result registers
   `TLFQ_ASSERT_SAME(a_rsp_origin, clock, reset, rsp_valid, $past(start && !busy, 2), "result without a matching request transfer")
   // an idle tick reports no process
   `TLFQ_ASSERT_SAME(a_idle_clean, clock, reset, rsp_valid && rsp_idle, rsp_running_id == '0 && rsp_running_level == tlfq_pkg::LEVEL_0 && !rsp_finished && !rsp_demoted, "idle tick reports a running process")
   // FCFS level never demotes; a process cannot finish and demote at once
   `TLFQ_ASSERT_SAME(a_demote_rule, clock, reset, rsp_valid && rsp_demoted, !rsp_finished && rsp_running_level != tlfq_pkg::LEVEL_2 && !rsp_idle, "illegal demotion")

endmodule
